// ===== src/spru_pkg.sv =====
// shared types and constants of the sprite pen run unpacker
`timescale 1ns / 1ps

package spru_pkg;

    localparam int WORD_W     = 32;
    localparam int BUF_W      = 64;
    localparam int HELD_W     = 7;
    localparam int PEEK_W     = 9;
    localparam int AMT_W      = 4;
    localparam int BUDGET_W   = 11;
    localparam int BPP_W      = 3;
    localparam int PEN_W      = 4;
    localparam int RUN_W      = 5;
    localparam int OFFSET_W   = 8;
    localparam int KIND_W     = 3;
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 3;

    localparam logic [AMT_W-1:0]  HDR_BITS  = 4'd5;
    localparam logic [HELD_W-1:0] BYTE_BITS = 7'd8;
    localparam logic [HELD_W-1:0] WORD_BITS = 7'd32;

    localparam logic [BPP_W-1:0] BPP_MIN   = 3'd1;
    localparam logic [BPP_W-1:0] BPP_MAX   = 3'd4;
    localparam logic [BPP_W-1:0] BPP_RESET = 3'd4;

    localparam logic [CFG_IDX_W-1:0] CFG_BITS_PER_PEN = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_LITERAL_ONLY = 1'b1;

    typedef enum logic [KIND_W-1:0] {
        K_SPRITE_END  = 3'd0,
        K_QUADRANT    = 3'd1,
        K_LINE_START  = 3'd2,
        K_PEN_RUN     = 3'd3,
        K_LINE_END    = 3'd4,
        K_DATA_NEEDED = 3'd5
    } t_kind;

    typedef struct packed {
        logic              load;
        logic              append;
        logic              consume;
        logic [AMT_W-1:0]  amt;
        logic [WORD_W-1:0] word;
    } t_buf_ctrl;

    typedef struct packed {
        logic [HELD_W-1:0] held;
        logic [PEEK_W-1:0] peek;
    } t_buf_stat;

    typedef struct packed {
        t_kind               kind;
        logic [PEN_W-1:0]    pen;
        logic [RUN_W-1:0]    run_length;
        logic [OFFSET_W-1:0] line_offset;
        logic                last;
    } t_result;

endpackage

// ===== src/spru_ifs.sv =====
// channel interfaces of the sprite pen run unpacker
`timescale 1ns / 1ps

interface spru_in_if;
    logic        valid;
    logic        ready;
    logic        cmd;
    logic [31:0] data_word;

    modport source (output valid, output cmd, output data_word, input ready);
    modport sink (input valid, input cmd, input data_word, output ready);
endinterface

interface spru_out_if;
    logic       valid;
    logic       ready;
    logic [2:0] kind;
    logic [3:0] pen;
    logic [4:0] run_length;
    logic [7:0] line_offset;
    logic       last;

    modport source (output valid, output kind, output pen, output run_length,
                    output line_offset, output last, input ready);
    modport sink (input valid, input kind, input pen, input run_length,
                  input line_offset, input last, output ready);
endinterface

interface spru_cfg_if;
    logic       valid;
    logic       ready;
    logic       index;
    logic [2:0] data;

    modport source (output valid, output index, output data, input ready);
    modport sink (input valid, input index, input data, output ready);
endinterface

// ===== src/spru_bitbuf.sv =====
// msb-first bit buffer with shared load, append and consume shifter
`timescale 1ns / 1ps

module spru_bitbuf import spru_pkg::*; (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  t_buf_ctrl i_ctrl,
    output t_buf_stat o_stat
);

    logic [BUF_W-1:0]  r_buf;
    logic [HELD_W-1:0] r_held;
    logic [WORD_W-1:0] stream;

    // byte 0 is read first
    assign stream = {i_ctrl.word[7:0], i_ctrl.word[15:8],
                     i_ctrl.word[23:16], i_ctrl.word[31:24]};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_held <= '0;
        end else if (i_ctrl.load) begin
            r_held <= WORD_BITS - BYTE_BITS;
        end else if (i_ctrl.append) begin
            r_held <= r_held + WORD_BITS;
        end else if (i_ctrl.consume) begin
            r_held <= r_held - {{(HELD_W-AMT_W){1'b0}}, i_ctrl.amt};
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctrl.load) begin
            r_buf <= {stream[WORD_W-9:0], {(BUF_W-WORD_W+8){1'b0}}};
        end else if (i_ctrl.append) begin
            r_buf <= r_buf | ({stream, {(BUF_W-WORD_W){1'b0}}} >> r_held);
        end else if (i_ctrl.consume) begin
            r_buf <= r_buf << i_ctrl.amt;
        end
    end

    assign o_stat.held = r_held;
    assign o_stat.peek = r_buf[BUF_W-1 -: PEEK_W];

endmodule

// ===== src/sprite_pen_run_unpacker.sv =====
// sprite pen run unpacker: one decode step per unstalled cycle over a shared bit buffer
// a start word's first result is registered and valid the cycle after it is accepted;
//   an append word is accepted in S_IDLE and its first result comes from S_DECODE
// throughput: one result per cycle while the output is not stalled; a new word is
//   accepted only in S_IDLE, and an append with no active line gives no result
// reset clears line and packet state, bits_per_pen resets to 4, literal_only to 0
`timescale 1ns / 1ps

module sprite_pen_run_unpacker import spru_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    spru_in_if.sink     i_in,
    spru_out_if.source  o_out,
    spru_cfg_if.sink    i_cfg
);

    typedef enum logic {S_IDLE, S_DECODE} t_state;

    t_state              r_state;
    logic [BPP_W-1:0]    r_bpp;
    logic                r_lit_only;
    logic [BUDGET_W-1:0] r_line_left;
    logic                r_pk_lit;
    logic [PEN_W-1:0]    r_pk_left;
    logic                r_line_active;
    logic                r_out_vld;
    t_result             r_out;

    t_buf_ctrl           buf_ctrl;
    t_buf_stat           buf_stat;

    logic                step_en;
    logic                in_acc;
    logic [BPP_W-1:0]    bpp;
    logic [1:0]          pen_shift;
    logic                in_lit;
    logic                hdr;
    logic [AMT_W-1:0]    need;
    logic                budget_end;
    logic                starved;
    logic                flag;
    logic [PEN_W-1:0]    cnt;
    logic [PEN_W-1:0]    pen;
    logic [OFFSET_W-1:0] offset;

    spru_bitbuf u_bitbuf (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctrl  (buf_ctrl),
        .o_stat  (buf_stat)
    );

    assign step_en     = !r_out_vld || o_out.ready;
    assign i_in.ready  = (r_state == S_IDLE) && step_en;
    assign in_acc      = i_in.valid && i_in.ready;
    assign i_cfg.ready = 1'b1;

    always_comb begin
        if (r_bpp == '0) begin
            bpp = BPP_MIN;
        end else if (r_bpp > BPP_MAX) begin
            bpp = BPP_MAX;
        end else begin
            bpp = r_bpp;
        end
        pen_shift  = 2'(BPP_MAX - bpp);
        in_lit     = r_pk_lit && (r_pk_left != '0);
        hdr        = !r_lit_only && !in_lit;
        need       = {1'b0, bpp} + (hdr ? HDR_BITS : '0);
        budget_end = r_line_left <= {{(BUDGET_W-AMT_W){1'b0}}, need};
        starved    = buf_stat.held < {{(HELD_W-AMT_W){1'b0}}, need};
        flag       = buf_stat.peek[8];
        cnt        = buf_stat.peek[7:4];
        pen        = hdr ? (buf_stat.peek[3:0] >> pen_shift)
                         : (buf_stat.peek[8:5] >> pen_shift);
        offset     = i_in.data_word[7:0];
    end

    always_comb begin
        buf_ctrl.load    = in_acc && !i_in.cmd;
        buf_ctrl.append  = in_acc && i_in.cmd && r_line_active;
        buf_ctrl.consume = (r_state == S_DECODE) && step_en && !budget_end && !starved;
        buf_ctrl.amt     = need;
        buf_ctrl.word    = i_in.data_word;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state       <= S_IDLE;
            r_bpp         <= BPP_RESET;
            r_lit_only    <= 1'b0;
            r_line_left   <= '0;
            r_pk_lit      <= 1'b0;
            r_pk_left     <= '0;
            r_line_active <= 1'b0;
            r_out_vld     <= 1'b0;
        end else begin
            if (i_cfg.valid) begin
                unique case (i_cfg.index)
                    CFG_BITS_PER_PEN: r_bpp      <= i_cfg.data;
                    CFG_LITERAL_ONLY: r_lit_only <= i_cfg.data[0];
                    default:          r_bpp      <= r_bpp;
                endcase
            end
            unique case (r_state)
                S_IDLE: begin
                    if (in_acc && !i_in.cmd) begin
                        r_pk_lit          <= 1'b0;
                        r_pk_left         <= '0;
                        r_out_vld         <= 1'b1;
                        r_out.pen         <= '0;
                        r_out.run_length  <= '0;
                        r_out.line_offset <= offset;
                        if (offset == 8'd0) begin
                            r_out.kind    <= K_SPRITE_END;
                            r_out.last    <= 1'b1;
                            r_line_active <= 1'b0;
                            r_line_left   <= '0;
                        end else if (offset == 8'd1) begin
                            r_out.kind    <= K_QUADRANT;
                            r_out.last    <= 1'b1;
                            r_line_active <= 1'b0;
                            r_line_left   <= '0;
                        end else begin
                            r_out.kind    <= K_LINE_START;
                            r_out.last    <= 1'b0;
                            r_line_active <= 1'b1;
                            r_line_left   <= {offset - 8'd1, 3'b000};
                            r_state       <= S_DECODE;
                        end
                    end else begin
                        if (step_en) begin
                            r_out_vld <= 1'b0;
                        end
                        if (in_acc && r_line_active) begin
                            r_state <= S_DECODE;
                        end
                    end
                end
                S_DECODE: begin
                    if (step_en) begin
                        r_out_vld         <= 1'b1;
                        r_out.line_offset <= '0;
                        if (budget_end) begin
                            r_out.kind       <= K_LINE_END;
                            r_out.pen        <= '0;
                            r_out.run_length <= '0;
                            r_out.last       <= 1'b1;
                            r_line_active    <= 1'b0;
                            r_state          <= S_IDLE;
                        end else if (starved) begin
                            r_out.kind       <= K_DATA_NEEDED;
                            r_out.pen        <= '0;
                            r_out.run_length <= '0;
                            r_out.last       <= 1'b1;
                            r_state          <= S_IDLE;
                        end else begin
                            r_line_left <= r_line_left - {{(BUDGET_W-AMT_W){1'b0}}, need};
                            if (hdr && !flag && (cnt == '0)) begin
                                r_pk_lit         <= 1'b0;
                                r_pk_left        <= '0;
                                r_out.kind       <= K_LINE_END;
                                r_out.pen        <= '0;
                                r_out.run_length <= '0;
                                r_out.last       <= 1'b1;
                                r_line_active    <= 1'b0;
                                r_state          <= S_IDLE;
                            end else begin
                                r_out.kind <= K_PEN_RUN;
                                r_out.pen  <= pen;
                                r_out.last <= 1'b0;
                                if (!hdr) begin
                                    r_out.run_length <= 5'd1;
                                    if (!r_lit_only) begin
                                        r_pk_left <= r_pk_left - 4'd1;
                                    end
                                end else if (flag) begin
                                    r_pk_lit         <= 1'b1;
                                    r_pk_left        <= cnt;
                                    r_out.run_length <= 5'd1;
                                end else begin
                                    r_pk_lit         <= 1'b0;
                                    r_pk_left        <= '0;
                                    r_out.run_length <= {1'b0, cnt} + 5'd1;
                                end
                            end
                        end
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_out.valid       = r_out_vld;
    assign o_out.kind        = r_out.kind;
    assign o_out.pen         = r_out.pen;
    assign o_out.run_length  = r_out.run_length;
    assign o_out.line_offset = r_out.line_offset;
    assign o_out.last        = r_out.last;

endmodule

// ===== tb/sv/spru_decode_checker.sv =====
// passive checker of the sprite pen run unpacker: predicts every result and compares it
`timescale 1ns / 1ps

module spru_decode_checker import spru_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    spru_in_if         i_in,
    spru_out_if        i_out,
    spru_cfg_if        i_cfg,
    output int         o_fail_count,
    output int         o_pending,
    output int         o_words_decoded,
    output int         o_results_checked
);

    bit                  stream_bits[$];
    logic [BUDGET_W-1:0] line_budget;
    logic                lit_pkt;
    logic [3:0]          lit_pens_left;
    logic                line_on;
    logic [BPP_W-1:0]    cfg_bpp;
    logic                cfg_lit_only;
    t_result             due_results[$];

    function automatic logic [7:0] pull_bits(input int n);
        logic [7:0] v;
        v = '0;
        for (int i = 0; i < n; i++) begin
            v = {v[6:0], stream_bits.pop_front()};
        end
        return v;
    endfunction

    function automatic t_result make_result(input t_kind k, input logic [3:0] pen,
                                            input logic [4:0] run, input logic [7:0] off);
        t_result r;
        r.kind        = k;
        r.pen         = pen;
        r.run_length  = run;
        r.line_offset = off;
        r.last        = 1'b0;
        return r;
    endfunction

    // bytes go in lowest first, each one msb first
    task automatic load_bytes(input logic [31:0] w);
        for (int i = 0; i < 4; i++) begin
            if (stream_bits.size() <= 56) begin
                for (int b = 7; b >= 0; b--) begin
                    stream_bits.push_back(w[8*i + b]);
                end
            end
        end
    endtask

    task automatic decode_word(input logic cmd, input logic [31:0] w);
        t_result    res[$];
        logic [7:0] off;
        logic [7:0] got;
        logic [3:0] bpp_eff;
        logic [3:0] need;
        logic [3:0] cnt;
        logic       in_lit;
        logic       decoding;
        decoding = 1'b0;
        bpp_eff  = (cfg_bpp == 3'd0) ? 4'd1 : ((cfg_bpp > BPP_MAX) ? 4'd4 : {1'b0, cfg_bpp});
        if (cmd == 1'b0) begin
            stream_bits.delete();
            lit_pkt       = 1'b0;
            lit_pens_left = '0;
            line_on       = 1'b0;
            line_budget   = '0;
            load_bytes(w);
            off = pull_bits(8);
            if (off == 8'd0) begin
                res.push_back(make_result(K_SPRITE_END, 4'd0, 5'd0, off));
            end else if (off == 8'd1) begin
                res.push_back(make_result(K_QUADRANT, 4'd0, 5'd0, off));
            end else begin
                res.push_back(make_result(K_LINE_START, 4'd0, 5'd0, off));
                line_budget = {off - 8'd1, 3'b000};
                line_on     = 1'b1;
                decoding    = 1'b1;
            end
        end else if (line_on) begin
            load_bytes(w);
            decoding = 1'b1;
        end
        while (decoding) begin
            in_lit = lit_pkt && (lit_pens_left != 4'd0);
            need   = bpp_eff + ((cfg_lit_only || in_lit) ? 4'd0 : HDR_BITS);
            if (line_budget <= need) begin
                line_on  = 1'b0;
                decoding = 1'b0;
                res.push_back(make_result(K_LINE_END, 4'd0, 5'd0, 8'd0));
            end else if (stream_bits.size() < need) begin
                decoding = 1'b0;
                res.push_back(make_result(K_DATA_NEEDED, 4'd0, 5'd0, 8'd0));
            end else begin
                line_budget = line_budget - need;
                if (cfg_lit_only || in_lit) begin
                    if (!cfg_lit_only) begin
                        lit_pens_left = lit_pens_left - 4'd1;
                    end
                    got = pull_bits(bpp_eff);
                    res.push_back(make_result(K_PEN_RUN, got[3:0], 5'd1, 8'd0));
                end else begin
                    got = pull_bits(1);
                    cnt = 4'(pull_bits(4));
                    if (got[0]) begin
                        lit_pkt       = 1'b1;
                        lit_pens_left = cnt;
                        got = pull_bits(bpp_eff);
                        res.push_back(make_result(K_PEN_RUN, got[3:0], 5'd1, 8'd0));
                    end else begin
                        lit_pkt       = 1'b0;
                        lit_pens_left = '0;
                        if (cnt != 4'd0) begin
                            got = pull_bits(bpp_eff);
                            res.push_back(make_result(K_PEN_RUN, got[3:0],
                                                      {1'b0, cnt} + 5'd1, 8'd0));
                        end else begin
                            line_on  = 1'b0;
                            decoding = 1'b0;
                            res.push_back(make_result(K_LINE_END, 4'd0, 5'd0, 8'd0));
                        end
                    end
                end
            end
        end
        if (res.size() > 0) begin
            res[res.size()-1].last = 1'b1;
            foreach (res[i]) begin
                due_results.push_back(res[i]);
            end
            o_words_decoded++;
        end
    endtask

    always @(posedge i_clk) begin
        t_result want;
        if (!i_rst_n) begin
            stream_bits.delete();
            due_results.delete();
            line_budget       = '0;
            lit_pkt           = 1'b0;
            lit_pens_left     = '0;
            line_on           = 1'b0;
            cfg_bpp           = BPP_RESET;
            cfg_lit_only      = 1'b0;
            o_fail_count      = 0;
            o_words_decoded   = 0;
            o_results_checked = 0;
        end else begin
            if (i_cfg.valid && i_cfg.ready) begin
                if (i_cfg.index == CFG_BITS_PER_PEN) begin
                    cfg_bpp = i_cfg.data;
                end else begin
                    cfg_lit_only = i_cfg.data[0];
                end
            end
            if (i_out.valid && i_out.ready) begin
                if (due_results.size() == 0) begin
                    o_fail_count++;
                    if (o_fail_count <= 10) begin
                        $display("unexpected result: kind %0d pen %0d run %0d offset %0d last %0d",
                                 i_out.kind, i_out.pen, i_out.run_length, i_out.line_offset,
                                 i_out.last);
                    end
                end else begin
                    want = due_results.pop_front();
                    o_results_checked++;
                    if (i_out.kind !== want.kind || i_out.pen !== want.pen ||
                        i_out.run_length !== want.run_length ||
                        i_out.line_offset !== want.line_offset || i_out.last !== want.last) begin
                        o_fail_count++;
                        if (o_fail_count <= 10) begin
                            $display("mismatch: expected kind %0d pen %0d run %0d offset %0d last %0d",
                                     want.kind, want.pen, want.run_length, want.line_offset,
                                     want.last);
                            $display("          actual   kind %0d pen %0d run %0d offset %0d last %0d",
                                     i_out.kind, i_out.pen, i_out.run_length, i_out.line_offset,
                                     i_out.last);
                        end
                    end
                end
            end
            if (i_in.valid && i_in.ready) begin
                decode_word(i_in.cmd, i_in.data_word);
            end
        end
        o_pending = due_results.size();
    end

endmodule

// ===== tb/sv/sprite_pen_run_unpacker_tb.sv =====
// testbench top of the sprite pen run unpacker: stimulus, idling and verdict
`timescale 1ns / 1ps

module sprite_pen_run_unpacker_tb;
    import spru_pkg::*;

    localparam int CLK_PERIOD     = 12;
    localparam int WATCHDOG_LIMIT = 3000;
    localparam int HOLD_CYCLES    = 300;
    localparam int PHASES         = 8;
    localparam int WORDS_PER_PHASE = 56;

    // per phase register settings, pen widths outside 1..4 included
    localparam logic [3*PHASES-1:0] BPP_PLAN = {3'd7, 3'd0, 3'd1, 3'd4, 3'd3, 3'd2, 3'd4, 3'd1};
    localparam logic [PHASES-1:0]   LIT_PLAN = 8'b1011_0100;

    logic i_clk;
    logic i_rst_n;

    spru_in_if  in_ch ();
    spru_out_if out_ch ();
    spru_cfg_if cfg_ch ();

    int fail_count;
    int pending;
    int words_decoded;
    int results_checked;
    int words_sent = 0;
    int send_idle_pct = 0;
    int stall_pct = 0;
    int hold_request = 0;
    int hold_served = 0;
    int hold_left = 0;
    int quiet_cycles = 0;

    sprite_pen_run_unpacker u_top (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_ch),
        .o_out   (out_ch),
        .i_cfg   (cfg_ch)
    );

    spru_decode_checker u_chk (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_in              (in_ch),
        .i_out             (out_ch),
        .i_cfg             (cfg_ch),
        .o_fail_count      (fail_count),
        .o_pending         (pending),
        .o_words_decoded   (words_decoded),
        .o_results_checked (results_checked)
    );

    initial i_clk = 1'b0;
    always #(CLK_PERIOD / 2) i_clk = ~i_clk;

    // result receiver with random stalls and one long hold-off on request
    always @(negedge i_clk) begin
        if (hold_request != hold_served) begin
            hold_served  <= hold_request;
            hold_left    <= HOLD_CYCLES;
            out_ch.ready <= 1'b0;
        end else if (hold_left > 0) begin
            hold_left    <= hold_left - 1;
            out_ch.ready <= 1'b0;
        end else begin
            out_ch.ready <= ($urandom_range(0, 99) >= stall_pct);
        end
    end

    always @(posedge i_clk) begin
        if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready) ||
            (cfg_ch.valid && cfg_ch.ready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("watchdog: no transaction for %0d cycles", WATCHDOG_LIMIT);
            $display("tb: failure");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    function automatic logic [31:0] rand_data();
        case ($urandom_range(0, 9))
            0: return 32'h0000_0000;
            1: return 32'hFFFF_FFFF;
            default: return $urandom;
        endcase
    endfunction

    task automatic send_word(input logic cmd, input logic [31:0] w);
        while ($urandom_range(0, 99) < send_idle_pct) begin
            in_ch.valid <= 1'b0;
            @(negedge i_clk);
        end
        in_ch.valid     <= 1'b1;
        in_ch.cmd       <= cmd;
        in_ch.data_word <= w;
        @(posedge i_clk);
        while (!in_ch.ready) begin
            @(posedge i_clk);
        end
        words_sent++;
        @(negedge i_clk);
    endtask

    // leaves valid high so back to back writes need no gap
    task automatic write_reg(input logic idx, input logic [2:0] val);
        cfg_ch.valid <= 1'b1;
        cfg_ch.index <= idx;
        cfg_ch.data  <= val;
        @(posedge i_clk);
        while (!cfg_ch.ready) begin
            @(posedge i_clk);
        end
        @(negedge i_clk);
    endtask

    task automatic wait_idle();
        in_ch.valid <= 1'b0;
        while (pending != 0) begin
            @(negedge i_clk);
        end
        repeat (4) @(negedge i_clk);
    endtask

    // mostly a start word followed by appends, sometimes sprite end, quadrant or stray data
    task automatic send_line();
        int          sel;
        int          n_app;
        logic [7:0]  off;
        logic [31:0] w;
        sel = $urandom_range(0, 99);
        w   = rand_data();
        if (sel < 5) begin
            w[7:0] = 8'($urandom_range(0, 1));
            send_word(1'b0, w);
        end else if (sel < 12) begin
            send_word(1'b1, w);
        end else begin
            off = ($urandom_range(0, 9) == 0) ? 8'($urandom_range(2, 255))
                                              : 8'($urandom_range(2, 24));
            w[7:0] = off;
            send_word(1'b0, w);
            n_app = ((int'(off) - 1) * 8) / 32 + 1;
            if (n_app > 8) begin
                n_app = 8;
            end
            repeat ($urandom_range(0, n_app)) send_word(1'b1, rand_data());
        end
    endtask

    initial begin
        int target;
        in_ch.valid     = 1'b0;
        in_ch.cmd       = 1'b0;
        in_ch.data_word = '0;
        cfg_ch.valid    = 1'b0;
        cfg_ch.index    = 1'b0;
        cfg_ch.data     = '0;
        out_ch.ready    = 1'b0;
        i_rst_n         = 1'b0;
        repeat (10) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // directed words at the reset settings
        send_word(1'b1, 32'hFFFF_FFFF);
        send_word(1'b0, 32'h0000_0000);
        send_word(1'b0, 32'hFFFF_FF01);
        send_word(1'b0, 32'h0000_0002);
        send_word(1'b0, 32'h0000_00FF);
        send_word(1'b0, 32'hFFFF_FFFF);
        send_word(1'b1, 32'hFFFF_FFFF);
        send_word(1'b1, 32'h0000_0000);
        send_word(1'b0, 32'hA55A_7D30);
        send_word(1'b1, 32'h1234_5678);
        send_word(1'b1, 32'h8000_0001);
        send_word(1'b0, 32'h0000_0003);
        send_word(1'b1, 32'h0000_0000);
        wait_idle();

        for (int p = 0; p < PHASES; p++) begin
            write_reg(CFG_BITS_PER_PEN, BPP_PLAN[3*p +: 3]);
            write_reg(CFG_LITERAL_ONLY, {2'b00, LIT_PLAN[p]});
            cfg_ch.valid <= 1'b0;
            case (p % 4)
                0: begin send_idle_pct = 0;  stall_pct = 0;  end
                1: begin send_idle_pct = 70; stall_pct = 0;  end
                2: begin send_idle_pct = 0;  stall_pct = 70; end
                default: begin send_idle_pct = 9; stall_pct = 9; end
            endcase
            if (p == 4) begin
                hold_request <= hold_request + 1;
            end
            target = words_sent + WORDS_PER_PHASE / 2;
            while (words_sent < target) send_line();
            wait_idle();
            target = words_sent + WORDS_PER_PHASE / 2;
            while (words_sent < target) send_line();
            wait_idle();
        end

        repeat (8) @(negedge i_clk);
        $display("tb: %0d words sent, %0d with results, %0d results checked",
                 words_sent, words_decoded, results_checked);
        $display("tb: 8 register settings (pen widths 0..7, packet and literal-only modes), %s",
                 "four idle patterns and one long output hold-off");
        if (fail_count == 0 && pending == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

endmodule
